### src/lutf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lutf_pkg
// Shared types and constants for the binary 3x3 lookup filter.
// ----------------------------------------------------------------------------
package lutf_pkg;

    localparam int COORD_W     = 9;   // width of reported coordinates
    localparam int IDX_W       = 9;   // 3x3 window index
    localparam int TABLE_REGS  = 8;
    localparam int TABLE_SEL_W = 3;
    localparam int TABLE_REG_W = 64;
    localparam int TABLE_BIT_W = 6;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_LVL_W     = 3;

    // keeps the two older columns of the window after a left shift
    localparam logic [IDX_W-1:0] WINDOW_KEEP = 9'h1B6;

    typedef struct packed {
        logic pixel_in;
        logic frame_begin;
    } t_pix_in;

    typedef struct packed {
        logic               pixel_out;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               frame_done;
    } t_pix_out;

    // one classified request waiting for its table lookup
    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               done;
    } t_work;

endpackage
`default_nettype wire

### src/lutf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lutf_front
// Position tracking, line stores and 3x3 window; emits lookup requests.
// ----------------------------------------------------------------------------
module lutf_front #(
    parameter int FRAME_WIDTH  = 512,
    parameter int FRAME_HEIGHT = 512
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  lutf_pkg::t_pix_in                   i_pixel,
    input  wire  [lutf_pkg::Q_LVL_W-1:0]        i_q_level,
    output logic                                o_push,
    output lutf_pkg::t_work                     o_work
);
    import lutf_pkg::*;

    localparam int CW = (FRAME_WIDTH  > 1) ? $clog2(FRAME_WIDTH)  : 1;
    localparam int RW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam logic [CW-1:0] COL_LAST = CW'(FRAME_WIDTH - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(FRAME_HEIGHT - 1);

    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic               r_s1_valid;
    logic               r_s1_pix;
    logic [CW-1:0]      r_s1_col;
    logic               r_s1_emit;
    logic [COORD_W-1:0] r_s1_row1;
    logic [COORD_W-1:0] r_s1_col1;
    logic               r_s1_done;
    logic [IDX_W-1:0]   r_window;
    logic [1:0]         r_rd;           // {upper, middle} of the column
    logic [1:0]         r_lines [FRAME_WIDTH];

    logic               accept;
    logic [CW-1:0]      col_cur;
    logic [RW-1:0]      row_cur;
    logic [CW-1:0]      col_m1;
    logic [RW-1:0]      row_m1;
    logic               border;
    logic               pix_cur;
    logic               fwd;
    logic [Q_LVL_W:0]   busy;
    logic [IDX_W-1:0]   n_window;
    logic [CW-1:0]      n_col;
    logic [RW-1:0]      n_row;

    assign busy    = {1'b0, i_q_level} + {{Q_LVL_W{1'b0}}, r_s1_valid};
    assign o_ready = busy < (Q_LVL_W + 1)'(Q_DEPTH);
    assign accept  = i_valid && o_ready;

    // frame begin forces the origin
    assign col_cur = i_pixel.frame_begin ? '0 : r_col;
    assign row_cur = i_pixel.frame_begin ? '0 : r_row;
    assign col_m1  = col_cur - CW'(1);
    assign row_m1  = row_cur - RW'(1);
    assign border  = (row_cur == '0) || (row_cur == ROW_LAST) ||
                     (col_cur == '0) || (col_cur == COL_LAST);
    assign pix_cur = i_pixel.pixel_in && !border;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_cur == COL_LAST) begin
                n_col = '0;
                n_row = (row_cur == ROW_LAST) ? '0 : row_cur + RW'(1);
            end else begin
                n_col = col_cur + CW'(1);
                n_row = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= pix_cur;
            r_s1_col  <= col_cur;
            r_s1_emit <= (row_cur >= RW'(2)) && (col_cur >= CW'(2));
            r_s1_row1 <= COORD_W'(row_m1);
            r_s1_col1 <= COORD_W'(col_m1);
            r_s1_done <= (row_cur == ROW_LAST) && (col_cur == COL_LAST);
        end
    end

    // line stores: read one column ahead, write back the shifted pair
    assign fwd = r_s1_valid && (r_s1_col == col_cur);

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_lines[r_s1_col] <= {r_rd[0], r_s1_pix};
        end
        if (fwd) begin
            r_rd <= {r_rd[0], r_s1_pix};
        end else begin
            r_rd <= r_lines[col_cur];
        end
    end

    assign n_window = ((r_window << 1) & WINDOW_KEEP) |
                      {2'b00, r_rd[1], 2'b00, r_rd[0], 2'b00, r_s1_pix};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (r_s1_valid) begin
            r_window <= n_window;
        end
    end

    assign o_push       = r_s1_valid && r_s1_emit;
    assign o_work.index = n_window;
    assign o_work.row   = r_s1_row1;
    assign o_work.col   = r_s1_col1;
    assign o_work.done  = r_s1_done;

endmodule
`default_nettype wire

### src/lutf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lutf_queue
// Short FIFO of lookup requests between the front and back parts.
// ----------------------------------------------------------------------------
module lutf_queue (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_push,
    input  lutf_pkg::t_work                 i_work,
    input  wire                             i_pop,
    output lutf_pkg::t_work                 o_head,
    output logic [lutf_pkg::Q_LVL_W-1:0]    o_level
);
    import lutf_pkg::*;

    t_work              r_slots [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_LVL_W-1:0] r_level;
    logic [Q_LVL_W-1:0] n_level;

    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) begin
            n_level = r_level + Q_LVL_W'(1);
        end else if (!i_push && i_pop) begin
            n_level = r_level - Q_LVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_work;
        end
    end

    assign o_head  = r_slots[r_rd_ptr];
    assign o_level = r_level;

endmodule
`default_nettype wire

### src/lutf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lutf_back
// Lookup table registers, table lookup and output register.
// ----------------------------------------------------------------------------
module lutf_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [lutf_pkg::TABLE_SEL_W-1:0]    i_cfg_idx,
    input  wire  [lutf_pkg::TABLE_REG_W-1:0]    i_cfg_data,
    input  wire                                 i_avail,
    input  lutf_pkg::t_work                     i_head,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output lutf_pkg::t_pix_out                  o_pixel
);
    import lutf_pkg::*;

    logic [TABLE_REG_W-1:0] r_table [TABLE_REGS];
    logic                   r_out_valid;
    t_pix_out               r_out;
    logic [TABLE_REG_W-1:0] sel_reg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_REGS; k++) begin
                r_table[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_table[i_cfg_idx] <= i_cfg_data;
        end
    end

    // advance when the output slot is free or being drained
    assign o_pop   = i_avail && (!r_out_valid || i_ready);
    assign sel_reg = r_table[i_head.index[IDX_W-1:TABLE_BIT_W]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.pixel_out  <= sel_reg[i_head.index[TABLE_BIT_W-1:0]];
            r_out.out_row    <= i_head.row;
            r_out.out_col    <= i_head.col;
            r_out.frame_done <= i_head.done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out;

endmodule
`default_nettype wire

### src/binary_3x3_lut_image_filter_core.sv
`default_nettype none
// Path: a result for the pixel completing its window passes the stage-one
//   registers, the request queue and the output register.
// Throughput: one pixel per clock, sustained while the output is drained;
//   the four-entry request queue absorbs short output stalls.
// Reset: synchronous, active low; clears positions, window, queue and the
//   eight table registers. Line stores are not cleared.
// ----------------------------------------------------------------------------
// binary_3x3_lut_image_filter_core
// Binary 3x3 neighborhood filter with a 512-entry one-bit lookup table.
// ----------------------------------------------------------------------------
module binary_3x3_lut_image_filter_core #(
    parameter int FRAME_WIDTH  = 512,
    parameter int FRAME_HEIGHT = 512
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // pixel input channel
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  lutf_pkg::t_pix_in                   i_pixel,
    // filtered pixel output channel
    output logic                                o_valid,
    input  wire                                 i_ready,
    output lutf_pkg::t_pix_out                  o_pixel,
    // table register write port
    input  wire                                 i_cfg_we,
    input  wire  [lutf_pkg::TABLE_SEL_W-1:0]    i_cfg_idx,
    input  wire  [lutf_pkg::TABLE_REG_W-1:0]    i_cfg_data
);
    import lutf_pkg::*;

    // request path from front to back
    logic               q_push;
    logic               q_pop;
    t_work              q_in;
    t_work              q_head;
    logic [Q_LVL_W-1:0] q_level;
    logic               q_avail;

    // Front: track row and column, drop border pixels to zero, slide the
    // window over the two line stores and classify interior positions.
    // Ready holds low once the queue plus the request in flight could fill it.
    lutf_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_pixel   (i_pixel),
        .i_q_level (q_level),
        .o_push    (q_push),
        .o_work    (q_in)
    );

    // Queue: decouple the window stage from output back-pressure.
    lutf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_work  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_level (q_level)
    );

    assign q_avail = (q_level != '0);

    // Back: look the window index up in the table and register the result.
    lutf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_avail    (q_avail),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_pixel    (o_pixel)
    );

    // queue never holds more than its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level <= Q_LVL_W'(Q_DEPTH))
        else $error("request queue over depth");

    // no push into a full queue unless a pop frees a slot
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && (q_level == Q_LVL_W'(Q_DEPTH)) && !q_pop))
        else $error("request pushed into full queue");

    // a pop always lands in the output register
    a_pop_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_valid)
        else $error("popped request not presented");

    // the queue is never drained while empty
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_level != '0))
        else $error("pop from empty queue");

endmodule
`default_nettype wire
